// ===== hw/rtl/header_length_trailer_deframer_top_defines.svh =====
// Assertion macros used by the deframer back end (hltd_back).
`ifndef HEADER_LENGTH_TRAILER_DEFRAMER_TOP_DEFINES_SVH
`define HEADER_LENGTH_TRAILER_DEFRAMER_TOP_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define HLTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be seen outside reset.
`define HLTD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/hltd_pkg.sv =====
`timescale 1ns / 1ps
package hltd_pkg;

  localparam int unsigned STORE_DEPTH = 512;
  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned CW          = $clog2(STORE_DEPTH + 1);
  localparam int unsigned FRAME_MIN   = 11;
  localparam int unsigned MAX_RESULTS = 24;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] SYNC0 = 8'hAA;
  localparam logic [7:0] SYNC1 = 8'h55;
  localparam logic [7:0] TRL0  = 8'hCC;
  localparam logic [7:0] TRL1  = 8'h33;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic       MODE_PUSH  = 1'b0;
  localparam logic       MODE_READ  = 1'b1;
  localparam logic       KIND_FRAME = 1'b0;
  localparam logic       KIND_READ  = 1'b1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic [8:0] read_pos;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_flag;
    logic [8:0] payload_len;
    logic [8:0] frame_start;
    logic [7:0] read_data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       crc_en;
    logic [8:0] limit;
  } cfg_t;

  // One reflected CRC-32 byte update, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/hltd_ram.sv =====
`timescale 1ns / 1ps
module hltd_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 512
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/hltd_front.sv =====
`timescale 1ns / 1ps
module hltd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  hltd_pkg::in_item_t in_item_i,
  output logic               cmd_valid_o,
  output hltd_pkg::in_item_t cmd_o,
  input  logic               cmd_pop_i
);
  import hltd_pkg::*;

  // Two-entry command queue between the input side and the sequencer.
  in_item_t   slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       acc, take;

  assign full        = (cnt_q == 2'd2);
  assign acc         = push && !full;
  assign take        = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (acc) begin
      // Read items keep only their position; push items only their byte.
      slot_q[wp_q].mode     <= in_item_i.mode;
      slot_q[wp_q].rx_byte  <= (in_item_i.mode == MODE_PUSH) ? in_item_i.rx_byte : 8'd0;
      slot_q[wp_q].read_pos <= (in_item_i.mode == MODE_READ) ? in_item_i.read_pos : 9'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (acc) wp_q <= ~wp_q;
      if (take) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, take};
    end
  end
endmodule

// ===== hw/rtl/hltd_outq.sv =====
`timescale 1ns / 1ps
module hltd_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  hltd_pkg::out_item_t wdata_i,
  output logic                free_o,
  output logic                empty,
  input  logic                pop,
  output hltd_pkg::out_item_t out_item_o
);
  import hltd_pkg::*;

  out_item_t  slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign free_o     = (cnt_q != 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign wr         = wr_i && free_o;
  assign rd         = pop && !empty;
  assign out_item_o = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) slot_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== hw/rtl/hltd_back.sv =====
`timescale 1ns / 1ps
`include "header_length_trailer_deframer_top_defines.svh"
module hltd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hltd_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  hltd_pkg::in_item_t  cmd_i,
  output logic                cmd_pop_o,
  output logic                res_wr_o,
  output hltd_pkg::out_item_t res_o,
  input  logic                res_free_i
);
  import hltd_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_RD_OUT  = 5'd1;
  localparam logic [4:0] ST_PUSH    = 5'd2;
  localparam logic [4:0] ST_SCAN    = 5'd3;
  localparam logic [4:0] ST_B0      = 5'd4;
  localparam logic [4:0] ST_B1      = 5'd5;
  localparam logic [4:0] ST_HDR     = 5'd6;
  localparam logic [4:0] ST_FLAG    = 5'd7;
  localparam logic [4:0] ST_LEN0    = 5'd8;
  localparam logic [4:0] ST_LEN1    = 5'd9;
  localparam logic [4:0] ST_TRL0    = 5'd10;
  localparam logic [4:0] ST_TRL1    = 5'd11;
  localparam logic [4:0] ST_CRC     = 5'd12;
  localparam logic [4:0] ST_ACCEPT  = 5'd13;
  localparam logic [4:0] ST_FLUSH   = 5'd14;

  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [CW-1:0] FMIN_C  = CW'(FRAME_MIN);
  localparam logic [15:0]   MAXP_C  = 16'(MAX_PAYLOAD);

  logic [4:0]        state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [7:0]        b0_q, b0_d;
  logic [7:0]        flag_q, flag_d;
  logic [15:0]       len_q, len_d;
  logic [CW-1:0]     off_q, off_d;
  logic [31:0]       crc_q, crc_d;
  logic [31:0]       rx_q, rx_d;
  logic [7:0]        byte_q, byte_d;
  logic [NRES_W-1:0] n_q, n_d;
  logic              pend_v_q, pend_v_d;
  out_item_t         pend_q, pend_d;

  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [CW-1:0] roff;
  logic [7:0]    rdata;
  logic [15:0]   lim, len16;
  logic [CW-1:0] tot_new, tot;
  logic [31:0]   rx_full;

  hltd_ram #(.W(8), .D(STORE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (byte_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign lim     = ({7'd0, cfg_i.limit} > MAXP_C) ? MAXP_C : {7'd0, cfg_i.limit};
  assign len16   = {rdata, len_q[7:0]};
  assign tot_new = len16[CW-1:0] + FMIN_C;
  assign tot     = len_q[CW-1:0] + FMIN_C;
  assign rx_full = {rdata, rx_q[31:8]};
  assign waddr   = head_q + cnt_q[AW-1:0];

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    b0_d     = b0_q;
    flag_d   = flag_q;
    len_d    = len_q;
    off_d    = off_q;
    crc_d    = crc_q;
    rx_d     = rx_q;
    byte_d   = byte_q;
    n_d      = n_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    re       = 1'b0;
    roff     = '0;
    raddr    = head_q;
    we       = 1'b0;
    cmd_pop_o = 1'b0;
    res_wr_o  = 1'b0;
    res_o     = pend_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          n_d       = '0;
          pend_v_d  = 1'b0;
          byte_d    = cmd_i.rx_byte;
          if (cmd_i.mode == MODE_READ) begin
            re      = 1'b1;
            raddr   = cmd_i.read_pos[AW-1:0];
            state_d = ST_RD_OUT;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_RD_OUT: begin
        res_o = '{kind: KIND_READ, frame_flag: 8'd0, payload_len: 9'd0,
                  frame_start: 9'd0, read_data: rdata, last: 1'b1};
        if (res_free_i) begin
          res_wr_o = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_PUSH: begin
        if (cnt_q == DEPTH_C) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          we      = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q < CW'(2)) begin
          state_d = ST_FLUSH;
        end else begin
          re      = 1'b1;
          roff    = '0;
          state_d = ST_B0;
        end
      end
      ST_B0: begin
        b0_d    = rdata;
        re      = 1'b1;
        roff    = CW'(1);
        state_d = ST_B1;
      end
      ST_B1: begin
        if (b0_q == SYNC0 && rdata == SYNC1) begin
          state_d = ST_HDR;
        end else begin
          head_d = head_q + 1'b1;
          cnt_d  = cnt_q - 1'b1;
          b0_d   = rdata;
          if (cnt_q - 1'b1 < CW'(2)) begin
            state_d = ST_FLUSH;
          end else begin
            re   = 1'b1;
            roff = CW'(2);
          end
        end
      end
      ST_HDR: begin
        if (cnt_q < FMIN_C) begin
          state_d = ST_FLUSH;
        end else begin
          re      = 1'b1;
          roff    = CW'(2);
          state_d = ST_FLAG;
        end
      end
      ST_FLAG: begin
        flag_d  = rdata;
        re      = 1'b1;
        roff    = CW'(3);
        state_d = ST_LEN0;
      end
      ST_LEN0: begin
        len_d   = {8'd0, rdata};
        re      = 1'b1;
        roff    = CW'(4);
        state_d = ST_LEN1;
      end
      ST_LEN1: begin
        len_d = len16;
        if (len16 > lim) begin
          head_d  = head_q + AW'(2);
          cnt_d   = cnt_q - CW'(2);
          state_d = ST_SCAN;
        end else if (cnt_q < tot_new) begin
          state_d = ST_FLUSH;
        end else begin
          re      = 1'b1;
          roff    = tot_new - CW'(2);
          state_d = ST_TRL0;
        end
      end
      ST_TRL0: begin
        b0_d    = rdata;
        re      = 1'b1;
        roff    = tot - CW'(1);
        state_d = ST_TRL1;
      end
      ST_TRL1: begin
        if (b0_q == TRL0 && rdata == TRL1) begin
          if (cfg_i.crc_en) begin
            crc_d   = CRC_INIT;
            off_d   = '0;
            re      = 1'b1;
            roff    = '0;
            state_d = ST_CRC;
          end else begin
            state_d = ST_ACCEPT;
          end
        end else begin
          head_d  = head_q + AW'(2);
          cnt_d   = cnt_q - CW'(2);
          state_d = ST_SCAN;
        end
      end
      ST_CRC: begin
        // Bytes before the CRC field feed the CRC, the next four are the received value.
        if (off_q < len_q[CW-1:0] + CW'(5)) begin
          crc_d = crc_byte(crc_q, rdata);
        end else begin
          rx_d = rx_full;
        end
        if (off_q == len_q[CW-1:0] + CW'(8)) begin
          if ((crc_q ^ CRC_INIT) == rx_full) begin
            state_d = ST_ACCEPT;
          end else begin
            head_d  = head_q + AW'(2);
            cnt_d   = cnt_q - CW'(2);
            state_d = ST_SCAN;
          end
        end else begin
          off_d = off_q + 1'b1;
          re    = 1'b1;
          roff  = off_q + 1'b1;
        end
      end
      ST_ACCEPT: begin
        if (!pend_v_q || res_free_i) begin
          res_wr_o = pend_v_q;
          res_o    = pend_q;
          pend_v_d = 1'b1;
          pend_d   = '{kind: KIND_FRAME, frame_flag: flag_q, payload_len: len_q[8:0],
                       frame_start: 9'(head_q), read_data: 8'd0, last: 1'b0};
          head_d   = head_q + tot[AW-1:0];
          cnt_d    = cnt_q - tot;
          n_d      = n_q + 1'b1;
          state_d  = (n_q + 1'b1 == NRES_W'(MAX_RESULTS)) ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: begin
        res_o      = pend_q;
        res_o.last = 1'b1;
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (res_free_i) begin
          res_wr_o = 1'b1;
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (state_q != ST_IDLE) begin
      raddr = head_q + roff[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q   <= b0_d;
    flag_q <= flag_d;
    len_q  <= len_d;
    off_q  <= off_d;
    crc_q  <= crc_d;
    rx_q   <= rx_d;
    byte_q <= byte_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
    end
  end

  `HLTD_ASSERT(a_cnt_range, cnt_q <= DEPTH_C, "window count above store depth")
  `HLTD_NEVER(a_wr_full, res_wr_o && !res_free_i, "result written into full queue")
  `HLTD_ASSERT(a_nres, n_q <= NRES_W'(MAX_RESULTS), "too many descriptors for one push")
  `HLTD_NEVER(a_pop_busy, cmd_pop_o && state_q != ST_IDLE, "command taken while busy")
endmodule

// ===== hw/rtl/header_length_trailer_deframer_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     push / full               in_item_i  (mode, rx_byte, read_pos)
// result    empty / pop               out_item_o (kind, flag, len, start, data, last)
// config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A read beat passes through the idle and read-out states of the sequencer.
// A push beat stores its byte and then scans the window for headers; with CRC checking
// on, the sequencer also reads every byte of header, payload and CRC (len + 9).
// The window store has a single read port, so the sequencer reads one byte at a time
// and takes the next command only from its idle state.
// Reset clears the window (head and count) and the queues; stored bytes are not cleared.
// A two-entry command queue and a two-entry result queue let either side stall alone.
module header_length_trailer_deframer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  hltd_pkg::in_item_t                in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output hltd_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hltd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [8:0]                        cfg_data_i
);
  import hltd_pkg::*;

  // Configuration registers. They are to be written only while the block is idle, so
  // the sequencer reads them directly; the block itself does not enforce this.
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_en <= 1'b0;
      cfg_q.limit  <= 9'(MAX_PAYLOAD);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CRC_EN: cfg_q.crc_en <= cfg_data_i[0];
        CFG_LIMIT:  cfg_q.limit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end queues incoming beats; the back end walks the window store.
  logic      cmd_valid, cmd_pop;
  in_item_t  cmd;
  logic      res_wr, res_free;
  out_item_t res;

  hltd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  hltd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_wr_o    (res_wr),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  // Results wait here until the consumer pops them.
  hltd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (res_wr),
    .wdata_i    (res),
    .free_o     (res_free),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );
endmodule

// ===== tb/header_length_trailer_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the header/length/trailer deframer.
// A byte-level predictor tracks the window store, head and count, and works out
// the frame descriptors and read replies that each accepted input beat causes.
// Result beats are compared field by field with the oldest expected result.
module header_length_trailer_deframer_top_tb;
  import hltd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES   = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  header_length_trailer_deframer_top DUT (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Predictor state: a shadow copy of the window and the registers.
  logic [7:0] shadow_store [STORE_DEPTH];
  bit         shadow_written [STORE_DEPTH];
  int unsigned win_head, win_count;
  logic        crc_on;
  logic [8:0]  len_limit;

  out_item_t expected_q[$];
  int unsigned errors, frames_seen, reads_seen, beats_sent;
  int unsigned idle_cycles;
  bit          hold_off;

  function automatic logic [7:0] win_byte(int unsigned k);
    return shadow_store[(win_head + k) % STORE_DEPTH];
  endfunction

  function automatic void win_skip(int unsigned n);
    if (n > win_count) n = win_count;
    win_head  = (win_head + n) % STORE_DEPTH;
    win_count = win_count - n;
  endfunction

  function automatic logic [31:0] window_crc(int unsigned n);
    logic [31:0] c;
    c = 32'hFFFF_FFFF;
    for (int unsigned k = 0; k < n; k++) begin
      c ^= {24'd0, win_byte(k)};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return ~c;
  endfunction

  // Finds one complete frame at the front of the window, dropping junk.
  function automatic bit find_frame(output out_item_t d);
    int unsigned i, len, total, lim;
    logic [31:0] rx;
    lim = (len_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : len_limit;
    d = '0;
    forever begin
      i = 0;
      while (i + 1 < win_count && !(win_byte(i) == SYNC0 && win_byte(i + 1) == SYNC1)) i++;
      win_skip(i);
      if (win_count < FRAME_MIN) return 0;
      len = {win_byte(4), win_byte(3)};
      if (len > lim) begin
        win_skip(2);
        continue;
      end
      total = len + FRAME_MIN;
      if (win_count < total) return 0;
      if (win_byte(total - 2) == TRL0 && win_byte(total - 1) == TRL1) begin
        rx = {win_byte(len + 8), win_byte(len + 7), win_byte(len + 6), win_byte(len + 5)};
        if (!crc_on || window_crc(len + 5) == rx) begin
          d.kind        = KIND_FRAME;
          d.frame_flag  = win_byte(2);
          d.payload_len = len[8:0];
          d.frame_start = win_head[8:0];
          win_skip(total);
          return 1;
        end
      end
      win_skip(2);
    end
  endfunction

  // Works out the results of one accepted input beat and queues them.
  function automatic void predict_beat(in_item_t it);
    out_item_t d;
    int n;
    n = 0;
    if (it.mode == MODE_READ) begin
      d = '0;
      d.kind      = KIND_READ;
      d.read_data = shadow_store[it.read_pos % STORE_DEPTH];
      d.last      = 1'b1;
      expected_q.push_back(d);
      return;
    end
    if (win_count >= STORE_DEPTH) begin
      win_count = 0;
      return;
    end
    shadow_store[(win_head + win_count) % STORE_DEPTH]   = it.rx_byte;
    shadow_written[(win_head + win_count) % STORE_DEPTH] = 1'b1;
    win_count++;
    while (n < MAX_RESULTS && find_frame(d)) begin
      expected_q.push_back(d);
      n++;
    end
    if (n > 0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // Stimulus built up ahead of time, then played out by the sender process.
  in_item_t stim_q[$];
  logic [7:0] frame_buf[$];

  function automatic in_item_t push_item(logic [7:0] b);
    in_item_t it;
    it = '0;
    it.mode     = MODE_PUSH;
    it.rx_byte  = b;
    it.read_pos = 9'($urandom);
    return it;
  endfunction

  // Builds a frame; bad_crc and bad_trailer corrupt it on purpose.
  function automatic void build_frame(logic [7:0] flag, int unsigned len, bit bad_crc,
                                      bit bad_trailer);
    logic [31:0] c;
    frame_buf = {SYNC0, SYNC1, flag, len[7:0], len[15:8]};
    for (int unsigned k = 0; k < len; k++) frame_buf.push_back(8'($urandom));
    c = 32'hFFFF_FFFF;
    foreach (frame_buf[k]) begin
      c ^= {24'd0, frame_buf[k]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    c = ~c;
    if (bad_crc) c ^= 32'h1 << $urandom_range(31, 0);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
    frame_buf.push_back(c[23:16]);
    frame_buf.push_back(c[31:24]);
    frame_buf.push_back(bad_trailer ? 8'hC3 : TRL0);
    frame_buf.push_back(TRL1);
  endfunction

  function automatic void queue_frame();
    foreach (frame_buf[k]) stim_q.push_back(push_item(frame_buf[k]));
  endfunction

  // Mostly short payloads, now and then longer ones.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 75) return $urandom_range(8, 0);
    return $urandom_range(24, 9);
  endfunction

  // A read aimed at a written entry.
  function automatic bit read_item(output in_item_t it);
    int unsigned p;
    it = '0;
    for (int t = 0; t < 64; t++) begin
      p = $urandom_range(STORE_DEPTH - 1, 0);
      if (shadow_written[p]) begin
        it.mode     = MODE_READ;
        it.rx_byte  = 8'($urandom);
        it.read_pos = 9'(p);
        return 1;
      end
    end
    return 0;
  endfunction

  // Directed table: each row is one beat; has_exp marks rows whose result is
  // obvious, and exp_row holds it. The predictor checks every row anyway.
  typedef struct {
    in_item_t  item;
    bit        has_exp;
    out_item_t exp_row;
  } row_t;
  row_t directed_rows[$];

  function automatic out_item_t frame_desc(logic [7:0] flag, logic [8:0] len,
                                           logic [8:0] start);
    out_item_t d;
    d = '0;
    d.kind = KIND_FRAME;
    d.frame_flag = flag;
    d.payload_len = len;
    d.frame_start = start;
    d.last = 1'b1;
    return d;
  endfunction

  function automatic void add_row(in_item_t it, bit has_exp, out_item_t e);
    row_t r;
    r.item = it;
    r.has_exp = has_exp;
    r.exp_row = e;
    directed_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    in_item_t it;
    // Junk byte dropped ahead of the header; frame with empty payload, flag 0xFF.
    add_row(push_item(8'h00), 0, '0);
    build_frame(8'hFF, 0, 0, 0);
    foreach (frame_buf[k])
      add_row(push_item(frame_buf[k]), k == frame_buf.size() - 1,
              frame_desc(8'hFF, 9'd0, 9'd1));
    // Read back the two header bytes at positions 1 and 2.
    it = '0;
    it.mode = MODE_READ;
    it.rx_byte = 8'hFF;
    it.read_pos = 9'd1;
    add_row(it, 1, '{kind: KIND_READ, read_data: SYNC0, last: 1'b1, default: '0});
    it.read_pos = 9'd2;
    add_row(it, 1, '{kind: KIND_READ, read_data: SYNC1, last: 1'b1, default: '0});
  endfunction

  task automatic send_beat(in_item_t it);
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_beat(it);
    beats_sent++;
  endtask

  // Plays stim_q out in bursts with random gaps; push stays high inside a burst.
  task automatic play_stimulus();
    int unsigned burst;
    while (stim_q.size() > 0) begin
      burst = $urandom_range(12, 1);
      while (burst > 0 && stim_q.size() > 0) begin
        send_beat(stim_q.pop_front());
        burst--;
      end
      if ($urandom_range(3, 0) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
      end
    end
    push <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_q.size() > 0) @(posedge clk_i);
    // A push that yields no result may still be scanning: allow a full rescan.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_CRC_EN) crc_on = val[0];
    else if (idx == CFG_LIMIT) len_limit = val;
  endtask

  // One random phase: mostly well-formed frames, some broken ones, noise and reads.
  task automatic random_phase(int unsigned n_items);
    in_item_t it;
    int unsigned r, len;
    while (stim_q.size() < n_items) begin
      r = $urandom_range(99, 0);
      len = pick_len();
      if (r < 55) begin
        build_frame(8'($urandom), len, 0, 0);
        queue_frame();
      end else if (r < 65) begin
        build_frame(8'($urandom), len, 1, 0);
        queue_frame();
      end else if (r < 72) begin
        build_frame(8'($urandom), len, 0, 1);
        queue_frame();
      end else if (r < 77) begin
        // Header with a length field of at least 256.
        stim_q.push_back(push_item(SYNC0));
        stim_q.push_back(push_item(SYNC1));
        stim_q.push_back(push_item(8'($urandom)));
        stim_q.push_back(push_item(8'($urandom)));
        stim_q.push_back(push_item(8'($urandom_range(255, 1))));
      end else if (r < 90) begin
        repeat ($urandom_range(4, 1)) stim_q.push_back(push_item(8'($urandom)));
      end else begin
        stim_q.push_back(push_item(SYNC0));
      end
    end
    play_stimulus();
    // Reads go after the pushes so only written entries are asked for.
    repeat (6) if (read_item(it)) begin
      stim_q.push_back(it);
    end
    play_stimulus();
  endtask

  // Result side: random stall pattern, with one long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_item_o);
          errors++;
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          if (out_item_o !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_item_o);
            errors++;
          end
          if (e.kind == KIND_FRAME) frames_seen++;
          else reads_seen++;
        end
      end
      pop <= hold_off ? 1'b0 : ($urandom_range(9, 0) < 7);
    end
  end

  // Watchdog: counts cycles with no beat accepted on any channel.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    frames_seen = 0;
    reads_seen = 0;
    beats_sent = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    win_head = 0;
    win_count = 0;
    crc_on = 1'b0;
    len_limit = 9'd256;
    foreach (shadow_written[k]) shadow_written[k] = 1'b0;
    foreach (shadow_store[k]) shadow_store[k] = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: the table rows with a typed-in result
    // are checked against that value right when the predictor queues it.
    build_directed();
    foreach (directed_rows[k]) begin
      send_beat(directed_rows[k].item);
      if (directed_rows[k].has_exp) begin
        if (expected_q.size() == 0) begin
          $display("%0t: table row %0d expected %p actual no result", $time, k,
                   directed_rows[k].exp_row);
          errors++;
        end else if (expected_q[$] !== directed_rows[k].exp_row) begin
          $display("%0t: table row %0d expected %p actual %p", $time, k,
                   directed_rows[k].exp_row, expected_q[$]);
          errors++;
        end
      end
    end
    push <= 1'b0;
    wait_idle();

    // Extremes of the limit, CRC checking on, an unknown index.
    write_reg(CFG_CRC_EN, 9'd1);
    write_reg(CFG_LIMIT, 9'd0);
    build_frame(8'h00, 0, 0, 0);
    queue_frame();
    build_frame(8'h01, 1, 0, 0);
    queue_frame();
    build_frame(8'h02, 0, 1, 0);
    queue_frame();
    play_stimulus();
    wait_idle();
    write_reg(CFG_LIMIT, 9'h1FF);
    write_reg(CFG_UNKNOWN, 9'h155);
    // A length of 257 is above the saturated limit, so this header is false.
    stim_q.push_back(push_item(SYNC0));
    stim_q.push_back(push_item(SYNC1));
    stim_q.push_back(push_item(8'h40));
    stim_q.push_back(push_item(8'h01));
    stim_q.push_back(push_item(8'h01));
    build_frame(8'h80, 20, 0, 0);
    queue_frame();
    play_stimulus();
    wait_idle();

    // Random phases across several settings. In the first, the receiver holds
    // off for a long stretch so the block fills and stalls its input.
    write_reg(CFG_CRC_EN, 9'd0);
    write_reg(CFG_LIMIT, 9'd256);
    fork
      random_phase(30);
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    wait_idle();
    write_reg(CFG_CRC_EN, 9'd1);
    write_reg(CFG_LIMIT, 9'd16);
    random_phase(20);
    wait_idle();
    write_reg(CFG_LIMIT, 9'd300);
    random_phase(20);
    wait_idle();
    write_reg(CFG_CRC_EN, 9'd0);
    write_reg(CFG_LIMIT, 9'd5);
    random_phase(15);
    // A couple more short frames at the small limit.
    repeat (2) begin
      build_frame(8'($urandom), $urandom_range(5, 0), 0, 0);
      queue_frame();
    end
    play_stimulus();
    wait_idle();

    $display("Sent %0d input beats; checked %0d frame descriptors and %0d read replies.",
             beats_sent, frames_seen, reads_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, expected_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
